// ===== hw/rtl/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scanner.
// No dependencies; used by mbps_cell and masked_byte_pattern_scanner.
package mbps_pkg;

   localparam int REG_BYTES  = 32;   // pattern bytes held in registers
   localparam int REG_IDX_W  = 5;    // index bits for REG_BYTES
   localparam int LEN_W      = 7;    // holds a length up to 127
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_REG_W  = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_CARE      = 3'd4,
      CSR_LENGTH    = 3'd5
   } csr_index_type;

   typedef logic [REG_BYTES-1:0][BYTE_W-1:0] pattern_type;

   typedef struct packed {
      logic             shift;     // request taken and inside the address range
      logic [LEN_W-1:0] len_eff;   // length clamped to the window depth
   } scan_ctl_type;

endpackage

// ===== hw/rtl/mbps_cell.sv =====
// One window cell: holds one byte of the sliding window and checks it
// against the pattern byte that lines up with it. Depends on mbps_pkg.
module mbps_cell #(
   parameter int IDX = 0
) (
   input  logic                                clock,
   input  mbps_pkg::scan_ctl_type              ctl,
   input  mbps_pkg::pattern_type               pattern,
   input  logic [mbps_pkg::REG_BYTES-1:0]      care,
   input  logic [mbps_pkg::BYTE_W-1:0]         byte_prev,
   output logic [mbps_pkg::BYTE_W-1:0]         byte_out,
   output logic                                hit
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic [LEN_W-1:0]  sel;
   logic              in_use;
   logic              must;
   logic [BYTE_W-1:0] expect_byte;

   assign byte_in  = ctl.shift ? byte_prev : byte_ff;
   assign byte_out = byte_ff;

   // cell IDX holds the byte that lands at pattern position len-1-IDX
   always_comb begin
      sel    = ctl.len_eff - LEN_W'(IDX + 1);
      in_use = LEN_W'(IDX) < ctl.len_eff;
      if (sel < LEN_W'(REG_BYTES)) begin
         expect_byte = pattern[sel[REG_IDX_W-1:0]];
         must        = care[sel[REG_IDX_W-1:0]];
      end else begin
         expect_byte = '0;
         must        = 1'b1;
      end
      hit = !in_use || !must || (byte_prev == expect_byte);
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner, top level: config registers, address counter,
// window cell chain and result register. Depends on mbps_pkg and mbps_cell.
//
// One byte per request; a request is taken every cycle while the result
// register is empty or being drained, and a match shows on rsp in the cycle
// after its byte is taken. The window is a chain of MAX_PATTERN_BYTES cells
// that shift one place per accepted byte below the address limit; each cell
// checks its byte against the aligned pattern byte, and the hits are ANDed.
// tuser set on a request restarts the scan at address 0. Bytes at or above
// 2^ADDRESS_BITS are taken but ignored until the next restart.
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int ADDRESS_BITS      = 34
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [mbps_pkg::BYTE_W-1:0]            req_tdata,  // data_byte
   input  logic                                   req_tuser,  // restart
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((ADDRESS_BITS+7)/8)*8-1:0]      rsp_tdata,  // match_address, zero fill
   input  logic                                   csr_we,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import mbps_pkg::*;

   localparam int CNT_W    = ADDRESS_BITS + 1;
   localparam int TDATA_W  = ((ADDRESS_BITS + 7) / 8) * 8;

   pattern_type           pattern_ff;
   logic [REG_BYTES-1:0]  care_ff;
   logic [LEN_REG_W-1:0]  len_ff;

   logic [CNT_W-1:0]         cnt_ff, cnt_in, cnt_base;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDRESS_BITS-1:0]  rsp_addr_ff;

   logic                     take;
   logic                     at_limit;
   logic [LEN_W-1:0]         len_eff;
   logic [LEN_W-1:0]         len_m1;
   logic                     enough;
   logic                     match;
   logic [CNT_W-1:0]         start_addr;
   scan_ctl_type             ctl;

   logic [MAX_PATTERN_BYTES-1:0]             hits;
   logic [MAX_PATTERN_BYTES:0][BYTE_W-1:0]   chain;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= '1;
         len_ff     <= LEN_REG_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAT_0_7:   pattern_ff[7:0]   <= csr_wdata;
            CSR_PAT_8_15:  pattern_ff[15:8]  <= csr_wdata;
            CSR_PAT_16_23: pattern_ff[23:16] <= csr_wdata;
            CSR_PAT_24_31: pattern_ff[31:24] <= csr_wdata;
            CSR_CARE:      care_ff <= csr_wdata[REG_BYTES-1:0];
            CSR_LENGTH:    len_ff  <= csr_wdata[LEN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (LEN_W'(len_ff) > LEN_W'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = LEN_W'(len_ff);
      end
   end
   assign len_m1 = len_eff - LEN_W'(1);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign cnt_base   = req_tuser ? '0 : cnt_ff;
   assign at_limit   = cnt_base[ADDRESS_BITS];

   assign ctl.shift   = take && !at_limit;
   assign ctl.len_eff = len_eff;

   // cell chain
   assign chain[0] = req_tdata;
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      mbps_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pattern   (pattern_ff),
         .care      (care_ff),
         .byte_prev (chain[i]),
         .byte_out  (chain[i+1]),
         .hit       (hits[i])
      );
   end

   assign enough     = cnt_base >= CNT_W'(len_m1);
   assign match      = ctl.shift && (len_eff != '0) && enough && (&hits);
   assign start_addr = cnt_base - CNT_W'(len_m1);

   always_comb begin
      cnt_in = cnt_ff;
      if (take) begin
         cnt_in = at_limit ? cnt_base : cnt_base + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = match;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (match) begin
         rsp_addr_ff <= start_addr[ADDRESS_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_addr_ff);

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (CNT_W'(1) << ADDRESS_BITS))
      else $error("address counter past limit");

   a_limit_hold: assert property (@(posedge clock) disable iff (reset)
      (take && !req_tuser && cnt_ff[ADDRESS_BITS]) |=> (cnt_ff == $past(cnt_ff)))
      else $error("counter moved past limit");

   a_restart_short: assert property (@(posedge clock) disable iff (reset)
      (take && req_tuser && (len_eff > LEN_W'(1))) |=> !rsp_tvalid)
      else $error("match reported before a full window after restart");

   a_no_match_zero_len: assert property (@(posedge clock) disable iff (reset)
      (take && (len_eff == '0)) |=> !rsp_tvalid)
      else $error("match with zero pattern length");

endmodule

// ===== tb/masked_byte_pattern_scanner_tb.sv =====
// Testbench for masked_byte_pattern_scanner: a directed table, then random scan phases.
// Results are checked against the table or scan model. Depends on mbps_pkg and the RTL.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_tb;
   import mbps_pkg::*;

   localparam int MAXB     = 32;
   localparam int ADDR_W   = 34;
   localparam int RSP_W    = ((ADDR_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam logic [ADDR_W:0] ADDR_LIMIT = 35'd1 << ADDR_W;

   typedef enum logic [1:0] {ROW_BYTE, ROW_TYPED, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]  value;
      logic [BYTE_W-1:0]      data;
      logic                   restart;
      logic                   hit;
      logic [ADDR_W-1:0]      addr;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [BYTE_W-1:0]       req_tdata;   // data_byte
   logic                    req_tuser;   // restart
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_W-1:0]        rsp_tdata;   // match_address, zero fill
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // scan model state
   logic [BYTE_W-1:0]       window_copy [MAXB];
   logic [ADDR_W:0]         next_address;
   pattern_type             pattern_copy;
   logic [31:0]             care_copy;
   logic [LEN_REG_W-1:0]    length_copy;

   logic [ADDR_W-1:0]       pending_matches [$];
   row_type                 script [$];
   int                      error_count = 0;
   bit                      steady = 1'b0;
   bit                      stream_busy = 1'b0;

   masked_byte_pattern_scanner #(
      .MAX_PATTERN_BYTES (MAXB),
      .ADDRESS_BITS      (ADDR_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic advance_scan(input logic [BYTE_W-1:0] b, input logic rs,
                               output bit hit, output logic [ADDR_W-1:0] addr);
      int eff;
      logic [ADDR_W:0] first;
      hit  = 1'b0;
      addr = '0;
      if (rs) next_address = '0;
      if (next_address >= ADDR_LIMIT) return;
      for (int i = MAXB - 1; i > 0; i--) window_copy[i] = window_copy[i-1];
      window_copy[0] = b;
      first = next_address;
      next_address++;
      eff = (length_copy > MAXB) ? MAXB : int'(length_copy);
      if (eff == 0 || next_address < eff) return;
      hit = 1'b1;
      for (int j = 0; j < eff; j++) begin
         if (care_copy[j] && window_copy[eff-1-j] != pattern_copy[j]) hit = 1'b0;
      end
      if (hit) addr = ADDR_W'(first - (eff - 1));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      stream_busy = 1'b0;
   endtask

   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      if (stream_busy) settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx <= CSR_PAT_24_31) pattern_copy[8*int'(idx) +: 8] = val;
      else if (idx == CSR_CARE) care_copy = val[31:0];
      else if (idx == CSR_LENGTH) length_copy = val[LEN_REG_W-1:0];
   endtask

   // typed: expectation comes from the caller instead of the scan model
   task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic rs, input bit typed,
                            input bit typed_hit, input logic [ADDR_W-1:0] typed_addr);
      int gap;
      bit hit;
      logic [ADDR_W-1:0] addr;
      gap = steady ? 0 : $urandom_range(0, 6);
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= rs;
      do @(posedge clock); while (!req_tready);
      advance_scan(b, rs, hit, addr);
      if (typed) begin
         hit  = typed_hit;
         addr = typed_addr;
      end
      if (hit) pending_matches = {pending_matches, addr};
      stream_busy = 1'b1;
   endtask

   // mostly whole patterns with random wildcard bytes, some with a flipped bit, plus noise
   task automatic scan_phase(input logic [LEN_REG_W-1:0] len, input logic [31:0] care,
                             input fill_type fill, input int count);
      int sent;
      int span;
      int flip;
      logic [BYTE_W-1:0] b;
      logic [CSR_DATA_W-1:0] v;
      sent = 0;
      for (int k = 0; k < 4; k++) begin
         v = (fill == FILL_ONES) ? '1 : (fill == FILL_ZEROS) ? '0 : {$urandom, $urandom};
         program_reg(CSR_IDX_W'(CSR_PAT_0_7 + k), v);
      end
      program_reg(CSR_CARE, {32'b0, care});
      program_reg(CSR_LENGTH, {{(CSR_DATA_W-LEN_REG_W){1'b0}}, len});
      span = (length_copy > MAXB) ? MAXB : int'(length_copy);
      while (sent < count) begin
         if (span > 0 && $urandom_range(0, 9) < 6) begin
            flip = ($urandom_range(0, 6) == 0) ? $urandom_range(0, span - 1) : -1;
            for (int k = 0; k < span; k++) begin
               b = care_copy[k] ? pattern_copy[k] : BYTE_W'($urandom);
               if (k == flip) b ^= BYTE_W'(1 << $urandom_range(0, 7));
               feed_byte(b, $urandom_range(0, 39) == 0, 1'b0, 1'b0, '0);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               feed_byte(BYTE_W'($urandom), $urandom_range(0, 19) == 0, 1'b0, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   function automatic row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] val);
      row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.value   = val;
      return r;
   endfunction

   function automatic row_type byte_row(input logic [BYTE_W-1:0] b, input logic rs);
      row_type r;
      r = '0;
      r.kind    = ROW_BYTE;
      r.data    = b;
      r.restart = rs;
      return r;
   endfunction

   function automatic row_type typed_row(input logic [BYTE_W-1:0] b, input logic rs,
                                         input logic hit, input logic [ADDR_W-1:0] addr);
      row_type r;
      r = byte_row(b, rs);
      r.kind = ROW_TYPED;
      r.hit  = hit;
      r.addr = addr;
      return r;
   endfunction

   function automatic void add_row(input row_type r);
      script = {script, r};
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%t: %s", $realtime, msg);
   endtask

   initial begin : result_sink
      int stall;
      logic [ADDR_W-1:0] want;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_matches.size() == 0) begin
            flag_error($sformatf("unexpected match, address 0x%0h", rsp_tdata));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata !== RSP_W'(want))
               flag_error($sformatf("match_address mismatch: expected 0x%0h, got 0x%0h",
                                    want, rsp_tdata));
         end
      end
   end

   initial begin : stimulus
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_PAT_0_7;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      foreach (window_copy[i]) window_copy[i] = '0;
      next_address = '0;
      pattern_copy = '0;
      care_copy    = '1;
      length_copy  = LEN_REG_W'(1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values: single zero byte pattern, every byte cared
      add_row(typed_row(8'h00, 1'b0, 1'b1, 34'd0));
      add_row(typed_row(8'hFF, 1'b0, 1'b0, 34'd0));
      add_row(typed_row(8'h00, 1'b0, 1'b1, 34'd2));
      add_row(typed_row(8'h00, 1'b1, 1'b1, 34'd0));
      add_row(typed_row(8'h01, 1'b0, 1'b0, 34'd0));
      // two byte pattern; unknown indexes must leave it alone
      add_row(csr_row(CSR_PAT_0_7, 64'h5AA5));
      add_row(csr_row(CSR_LENGTH, 64'd2));
      add_row(csr_row(CSR_SPARE_6, 64'd0));
      add_row(csr_row(CSR_SPARE_7, 64'd0));
      add_row(byte_row(8'hA5, 1'b0));
      add_row(typed_row(8'h5A, 1'b1, 1'b0, 34'd0));   // window matches, scan too short
      add_row(typed_row(8'hA5, 1'b0, 1'b0, 34'd0));
      add_row(typed_row(8'h5A, 1'b0, 1'b1, 34'd1));
      // all wildcards
      add_row(csr_row(CSR_CARE, 64'd0));
      add_row(csr_row(CSR_LENGTH, 64'd3));
      add_row(byte_row(8'h12, 1'b1));
      add_row(typed_row(8'h34, 1'b0, 1'b0, 34'd0));
      add_row(typed_row(8'h56, 1'b0, 1'b1, 34'd0));
      // zero length never matches
      add_row(csr_row(CSR_LENGTH, 64'd0));
      add_row(typed_row(8'hFF, 1'b0, 1'b0, 34'd0));
      add_row(typed_row(8'h00, 1'b1, 1'b0, 34'd0));
      // all ones pattern
      add_row(csr_row(CSR_CARE, 64'hFFFF_FFFF));
      add_row(csr_row(CSR_PAT_0_7, '1));
      add_row(csr_row(CSR_PAT_8_15, '1));
      add_row(csr_row(CSR_PAT_16_23, '1));
      add_row(csr_row(CSR_PAT_24_31, '1));
      add_row(csr_row(CSR_LENGTH, 64'd1));
      add_row(typed_row(8'hFF, 1'b0, 1'b1, 34'd1));
      add_row(typed_row(8'hFE, 1'b0, 1'b0, 34'd0));

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR)
            program_reg(script[i].csr_idx, script[i].value);
         else
            feed_byte(script[i].data, script[i].restart, script[i].kind == ROW_TYPED,
                      script[i].hit, script[i].addr);
      end

      steady = 1'b1;
      scan_phase(6'd1, '1, FILL_RANDOM, 40);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd2, $urandom, FILL_RANDOM, 50);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd3, '1, FILL_RANDOM, 60);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd5, $urandom, FILL_RANDOM, 60);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd8, '1, FILL_RANDOM, 60);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd32, '1, FILL_ONES, 80);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd63, '0, FILL_RANDOM, 50);   // clamped to the window depth
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd0, $urandom, FILL_RANDOM, 40);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(6'd17, $urandom, FILL_RANDOM, 70);
      steady = ($urandom_range(0, 4) == 0);
      scan_phase(LEN_REG_W'($urandom_range(1, MAXB)), $urandom | $urandom, FILL_RANDOM, 70);
      steady = 1'b0;
      scan_phase(6'd4, '1, FILL_ZEROS, 50);

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("masked_byte_pattern_scanner_tb: clean");
      else
         $display("masked_byte_pattern_scanner_tb: errors");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("masked_byte_pattern_scanner_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/masked_byte_pattern_scanner.sv
tb/masked_byte_pattern_scanner_tb.sv
